// File: src/nqlv_pkg.sv
// ============================================================================
// nqlv_pkg
// Shared types and constants for the N-Quads line validator.
// ============================================================================
package nqlv_pkg;

   // Width of the saturating line counters
   localparam int COUNT_WIDTH = 32;

   // Width of the total fields carried in a result beat
   localparam int TOTAL_WIDTH = 32;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [TOTAL_WIDTH-1:0] total_type;

   // Byte codes the scanner looks for
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_COLON  = 8'h3A;

   // Terms in a statement and marks needed by the fast check
   localparam logic [1:0] TERMS_NEEDED = 2'd3;
   localparam logic [1:0] MARKS_NEEDED = 2'd3;
   localparam logic [1:0] QUOTES_CLOSE = 2'd3;

   // Register map
   localparam logic REG_PARSE_MODE = 1'b0;

   typedef enum logic [1:0] {
      STATUS_SKIPPED  = 2'd0,
      STATUS_ACCEPTED = 2'd1,
      STATUS_REJECTED = 2'd2
   } line_status_type;

   typedef enum logic [3:0] {
      PH_LSTART   = 4'd0,
      PH_COMMENT  = 4'd1,
      PH_GAP      = 4'd2,
      PH_IRI      = 4'd3,
      PH_BLANK    = 4'd4,
      PH_LIT_Q1   = 4'd5,
      PH_LIT_Q2   = 4'd6,
      PH_LIT_BODY = 4'd7,
      PH_LIT_ESC  = 4'd8,
      PH_TRIPLE   = 4'd9,
      PH_SUFFIX   = 4'd10,
      PH_CARET1   = 4'd11,
      PH_CARET2   = 4'd12,
      PH_DONE     = 4'd13
   } phase_type;

   // One beat handed to the scanner
   typedef struct packed {
      logic       advance;
      logic [7:0] data_byte;
      logic       close_line;
   } scan_beat_type;

   // Classification coming back from the scanner
   typedef struct packed {
      logic            fire;
      line_status_type status;
   } scan_result_type;

   // Term scanner fields touched when a term begins
   typedef struct packed {
      phase_type       phase;
      logic [1:0]      terms;
      line_status_type outcome;
      logic [1:0]      skip;
   } term_next_type;

endpackage

// File: src/nqlv_scanner.sv
// ============================================================================
// nqlv_scanner
// Per-line scan state: full term structure walk and fast mark counting.
// ============================================================================
module nqlv_scanner (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     parse_mode,
   input  nqlv_pkg::scan_beat_type  beat,
   output nqlv_pkg::scan_result_type result
);

   nqlv_pkg::phase_type       phase_ff, phase_in;
   logic [1:0]                terms_ff, terms_in;
   logic [1:0]                quote_ff, quote_in;
   logic [1:0]                skip_ff, skip_in;
   logic                      pending_ff, pending_in;
   nqlv_pkg::line_status_type outcome_ff, outcome_in;
   logic [1:0]                marks_ff, marks_in;
   logic                      dot_ff, dot_in;
   logic                      under_ff, under_in;

   logic [7:0]    c;
   logic          is_lf;
   logic          ordinary;
   logic          fire;
   logic          is_gap;
   logic          mark;

   function automatic logic gap_space(input logic [7:0] b);
      return (b == nqlv_pkg::CH_SPACE) || (b == nqlv_pkg::CH_TAB) ||
             (b == nqlv_pkg::CH_CR);
   endfunction

   function automatic nqlv_pkg::term_next_type begin_term(
      input logic [7:0]                b,
      input logic [1:0]                terms,
      input nqlv_pkg::line_status_type outcome,
      input logic [1:0]                skip
   );
      nqlv_pkg::term_next_type r;
      logic [1:0]              t;
      logic                    starts;
      r.phase   = nqlv_pkg::PH_DONE;
      r.terms   = terms;
      r.outcome = outcome;
      r.skip    = skip;
      t         = terms + 2'd1;
      starts    = 1'b1;
      if (b == nqlv_pkg::CH_LT) begin
         r.phase = nqlv_pkg::PH_IRI;
      end else if (b == nqlv_pkg::CH_UNDER) begin
         r.phase = nqlv_pkg::PH_BLANK;
         r.skip  = 2'd1;
      end else if (b == nqlv_pkg::CH_QUOTE) begin
         r.phase = nqlv_pkg::PH_LIT_Q1;
      end else begin
         starts    = 1'b0;
         r.outcome = nqlv_pkg::STATUS_REJECTED;
      end
      if (starts) begin
         r.terms = t;
         if (t == nqlv_pkg::TERMS_NEEDED) begin
            r.phase   = nqlv_pkg::PH_DONE;
            r.outcome = nqlv_pkg::STATUS_ACCEPTED;
         end
      end
      return r;
   endfunction

   assign c        = beat.data_byte;
   assign is_lf    = (c == nqlv_pkg::CH_LF);
   assign is_gap   = gap_space(c);
   assign ordinary = beat.advance && !beat.close_line && !is_lf;
   assign fire     = beat.advance && (beat.close_line ? pending_ff : is_lf);

   // Next state of the term walk and the fast counters
   always_comb begin
      nqlv_pkg::term_next_type tn;
      tn         = begin_term(c, terms_ff, outcome_ff, skip_ff);
      phase_in   = phase_ff;
      terms_in   = terms_ff;
      quote_in   = quote_ff;
      skip_in    = skip_ff;
      outcome_in = outcome_ff;
      pending_in = pending_ff;
      marks_in   = marks_ff;
      dot_in     = dot_ff;
      under_in   = under_ff;
      mark       = (c == nqlv_pkg::CH_LT) || (under_ff && c == nqlv_pkg::CH_COLON);

      if (fire) begin
         // clear the line
         phase_in   = nqlv_pkg::PH_LSTART;
         terms_in   = 2'd0;
         quote_in   = 2'd0;
         skip_in    = 2'd0;
         outcome_in = nqlv_pkg::STATUS_SKIPPED;
         pending_in = 1'b0;
         marks_in   = 2'd0;
         dot_in     = 1'b0;
         under_in   = 1'b0;
      end else if (ordinary) begin
         pending_in = 1'b1;
         if (mark && marks_ff != nqlv_pkg::MARKS_NEEDED) marks_in = marks_ff + 2'd1;
         under_in = (c == nqlv_pkg::CH_UNDER);
         if (c == nqlv_pkg::CH_DOT) dot_in = 1'b1;

         case (phase_ff)
            nqlv_pkg::PH_LSTART: begin
               if (is_gap) begin
                  phase_in = nqlv_pkg::PH_LSTART;
               end else if (c == nqlv_pkg::CH_HASH) begin
                  phase_in = nqlv_pkg::PH_COMMENT;
               end else begin
                  phase_in   = tn.phase;
                  terms_in   = tn.terms;
                  outcome_in = tn.outcome;
                  skip_in    = tn.skip;
               end
            end
            nqlv_pkg::PH_GAP: begin
               if (!is_gap) begin
                  phase_in   = tn.phase;
                  terms_in   = tn.terms;
                  outcome_in = tn.outcome;
                  skip_in    = tn.skip;
               end
            end
            nqlv_pkg::PH_IRI: begin
               if (c == nqlv_pkg::CH_GT) phase_in = nqlv_pkg::PH_GAP;
            end
            nqlv_pkg::PH_BLANK: begin
               if (skip_ff != 2'd0) begin
                  skip_in = skip_ff - 2'd1;
               end else if (c == nqlv_pkg::CH_SPACE || c == nqlv_pkg::CH_TAB) begin
                  phase_in = nqlv_pkg::PH_GAP;
               end else if (c == nqlv_pkg::CH_DOT) begin
                  phase_in   = tn.phase;
                  terms_in   = tn.terms;
                  outcome_in = tn.outcome;
                  skip_in    = tn.skip;
               end
            end
            nqlv_pkg::PH_LIT_Q1: begin
               if (c == nqlv_pkg::CH_QUOTE) begin
                  phase_in = nqlv_pkg::PH_LIT_Q2;
               end else if (c == nqlv_pkg::CH_BSLASH) begin
                  phase_in = nqlv_pkg::PH_LIT_ESC;
               end else begin
                  phase_in = nqlv_pkg::PH_LIT_BODY;
               end
            end
            nqlv_pkg::PH_LIT_Q2, nqlv_pkg::PH_SUFFIX: begin
               if (phase_ff == nqlv_pkg::PH_LIT_Q2 && c == nqlv_pkg::CH_QUOTE) begin
                  phase_in = nqlv_pkg::PH_TRIPLE;
                  quote_in = 2'd0;
               end else if (is_gap) begin
                  phase_in = nqlv_pkg::PH_SUFFIX;
               end else if (c == nqlv_pkg::CH_CARET) begin
                  phase_in = nqlv_pkg::PH_CARET1;
               end else if (c == nqlv_pkg::CH_AT) begin
                  phase_in = nqlv_pkg::PH_BLANK;
                  skip_in  = 2'd0;
               end else begin
                  phase_in   = tn.phase;
                  terms_in   = tn.terms;
                  outcome_in = tn.outcome;
                  skip_in    = tn.skip;
               end
            end
            nqlv_pkg::PH_TRIPLE: begin
               if (c == nqlv_pkg::CH_QUOTE) begin
                  if (quote_ff + 2'd1 == nqlv_pkg::QUOTES_CLOSE) begin
                     quote_in = 2'd0;
                     phase_in = nqlv_pkg::PH_GAP;
                  end else begin
                     quote_in = quote_ff + 2'd1;
                  end
               end else begin
                  quote_in = 2'd0;
               end
            end
            nqlv_pkg::PH_LIT_BODY: begin
               if (c == nqlv_pkg::CH_BSLASH) begin
                  phase_in = nqlv_pkg::PH_LIT_ESC;
               end else if (c == nqlv_pkg::CH_QUOTE) begin
                  phase_in = nqlv_pkg::PH_SUFFIX;
               end
            end
            nqlv_pkg::PH_LIT_ESC: begin
               phase_in = nqlv_pkg::PH_LIT_BODY;
            end
            nqlv_pkg::PH_CARET1: begin
               // a lone caret is not a term start: reject
               if (c == nqlv_pkg::CH_CARET) begin
                  phase_in = nqlv_pkg::PH_CARET2;
               end else begin
                  phase_in   = nqlv_pkg::PH_DONE;
                  outcome_in = nqlv_pkg::STATUS_REJECTED;
               end
            end
            nqlv_pkg::PH_CARET2: begin
               if (c == nqlv_pkg::CH_LT) begin
                  phase_in = nqlv_pkg::PH_IRI;
               end else if (is_gap) begin
                  phase_in = nqlv_pkg::PH_GAP;
               end else begin
                  phase_in   = tn.phase;
                  terms_in   = tn.terms;
                  outcome_in = tn.outcome;
                  skip_in    = tn.skip;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Classification of the finished line
   always_comb begin
      result.fire = fire;
      if (phase_ff == nqlv_pkg::PH_LSTART || phase_ff == nqlv_pkg::PH_COMMENT) begin
         result.status = nqlv_pkg::STATUS_SKIPPED;
      end else if (parse_mode) begin
         result.status = (phase_ff == nqlv_pkg::PH_DONE) ? outcome_ff
                                                          : nqlv_pkg::STATUS_REJECTED;
      end else if (marks_ff == nqlv_pkg::MARKS_NEEDED && dot_ff) begin
         result.status = nqlv_pkg::STATUS_ACCEPTED;
      end else begin
         result.status = nqlv_pkg::STATUS_REJECTED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= nqlv_pkg::PH_LSTART;
         terms_ff   <= 2'd0;
         quote_ff   <= 2'd0;
         skip_ff    <= 2'd0;
         pending_ff <= 1'b0;
         outcome_ff <= nqlv_pkg::STATUS_SKIPPED;
         marks_ff   <= 2'd0;
         dot_ff     <= 1'b0;
         under_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         terms_ff   <= terms_in;
         quote_ff   <= quote_in;
         skip_ff    <= skip_in;
         pending_ff <= pending_in;
         outcome_ff <= outcome_in;
         marks_ff   <= marks_in;
         dot_ff     <= dot_in;
         under_ff   <= under_in;
      end
   end

endmodule

// File: src/nquads_line_validator_top.sv
// ============================================================================
// nquads_line_validator_top
// Byte-stream N-Quads line classifier with running accept/reject totals.
// ============================================================================
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  ----------------------------------
//  req_      in   req_tvalid / req_tready   tdata: data_byte; tuser: close_line
//  rsp_      out  rsp_tvalid / rsp_tready   tdata: status, accepted, rejected
//  csr_      in   APB psel/penable/pready   reg 0 parse_mode at byte address 0
//
//  One byte per clock while the result slot is free. A beat lands in the input
//  register, walks the scanner's next-state decode and, if it ends a line,
//  loads the result register as the scanner state updates. The scanner
//  update sets the rate.
//  Reset (synchronous, active high) clears the line state, both totals and
//  parse_mode. A stalled result holds the input register; one input beat
//  still enters while the result waits.
//
module nquads_line_validator_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic [0:0]  req_tuser,    // [0] close_line

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // [1:0] line_status, [33:2] accepted_total,
                                     // [65:34] rejected_total, [71:66] zero

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Clamp a counter to the width of the total field
   function automatic nqlv_pkg::total_type clamp_total(input nqlv_pkg::count_type v);
      nqlv_pkg::count_type lim;
      lim = nqlv_pkg::count_type'({nqlv_pkg::TOTAL_WIDTH{1'b1}});
      if (nqlv_pkg::COUNT_WIDTH > nqlv_pkg::TOTAL_WIDTH && v > lim) begin
         return '1;
      end
      return nqlv_pkg::total_type'(v);
   endfunction

   // ---- configuration -------------------------------------------------------
   logic mode_ff, mode_in;
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == nqlv_pkg::REG_PARSE_MODE);
   assign mode_in    = csr_write ? csr_pwdata[0] : mode_ff;
   // only register 0 exists; addresses with paddr[2] clear read it, the rest read zero
   assign csr_prdata = (csr_paddr[2] == nqlv_pkg::REG_PARSE_MODE) ? {31'd0, mode_ff} : 32'd0;

   // ---- input register ------------------------------------------------------
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff,  s1_byte_in;
   logic       s1_close_ff, s1_close_in;
   logic       out_free;
   logic       s1_advance;
   logic       req_take;

   // the result slot is free when empty or being drained this cycle
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_close_in = s1_close_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_close_in = req_tuser[0];
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---- line scanner --------------------------------------------------------
   nqlv_pkg::scan_beat_type   beat;
   nqlv_pkg::scan_result_type scan;

   assign beat.advance    = s1_advance;
   assign beat.data_byte  = s1_byte_ff;
   assign beat.close_line = s1_close_ff;

   nqlv_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .parse_mode (mode_ff),
      .beat       (beat),
      .result     (scan)
   );

   // ---- totals and result register ------------------------------------------
   nqlv_pkg::count_type       acc_ff, acc_in;
   nqlv_pkg::count_type       rej_ff, rej_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   nqlv_pkg::line_status_type rsp_status_ff, rsp_status_in;
   nqlv_pkg::total_type       rsp_acc_ff, rsp_acc_in;
   nqlv_pkg::total_type       rsp_rej_ff, rsp_rej_in;

   always_comb begin
      acc_in        = acc_ff;
      rej_in        = rej_ff;
      rsp_status_in = rsp_status_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (scan.fire) begin
         // bump the matching total, holding at all ones
         if (scan.status == nqlv_pkg::STATUS_ACCEPTED && acc_ff != '1) acc_in = acc_ff + 1'b1;
         if (scan.status == nqlv_pkg::STATUS_REJECTED && rej_ff != '1) rej_in = rej_ff + 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_status_in = scan.status;
         rsp_acc_in    = clamp_total(acc_in);
         rsp_rej_in    = clamp_total(rej_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_rej_ff, rsp_acc_ff, rsp_status_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         rej_ff       <= '0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         rej_ff       <= rej_in;
      end
   end

   // payload holds, no reset needed
   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_close_ff   <= s1_close_in;
      rsp_status_ff <= rsp_status_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_rej_ff    <= rsp_rej_in;
   end

   // ---- assertions ----------------------------------------------------------
   // a line is classified only when the result slot can take it
   a_fire_slot_free: assert property (@(posedge clock) disable iff (reset)
      scan.fire |-> out_free)
      else $error("line classified while result slot is stalled");

   // a shown result never carries the unused status code
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == nqlv_pkg::STATUS_SKIPPED ||
                        rsp_status_ff == nqlv_pkg::STATUS_ACCEPTED ||
                        rsp_status_ff == nqlv_pkg::STATUS_REJECTED))
      else $error("illegal line status on result");

   // the accepted total moves only with an accepted line
   a_acc_moves: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && acc_ff != $past(acc_ff)) |->
         ($past(scan.fire) && $past(scan.status) == nqlv_pkg::STATUS_ACCEPTED))
      else $error("accepted total changed without an accepted line");

   // the rejected total moves only with a rejected line
   a_rej_moves: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && rej_ff != $past(rej_ff)) |->
         ($past(scan.fire) && $past(scan.status) == nqlv_pkg::STATUS_REJECTED))
      else $error("rejected total changed without a rejected line");

endmodule
